/* sv/can_frame_crc8_alive_generator_top_assert.svh */
// Assertion macros used by the generator's top-level RTL file.
// Each macro takes a label, an antecedent and a consequent, sampled on clk
// and ignored while rst_n is low.
`ifndef CAN_FRAME_CRC8_ALIVE_GENERATOR_TOP_ASSERT_SVH
`define CAN_FRAME_CRC8_ALIVE_GENERATOR_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define CFCAG_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cfcag assertion failed");
`define CFCAG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cfcag assertion failed");
`else
`define CFCAG_ASSERT_SAME(label, ante, cons)
`define CFCAG_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* sv/cfcag_pkg.sv */
package cfcag_pkg;

  localparam int SIG_COUNT      = 16;
  localparam int SIG_W          = 12;
  localparam int IDX_W          = 4;
  localparam int OP_W           = 2;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 16;
  localparam int ID_W           = 11;
  localparam int PAYLOAD_W      = 64;
  localparam int TIME_WIDTH_DEF = 32;
  localparam int CRC_MSG_W      = 72;

  localparam logic [ID_W-1:0] ID_SPEED  = 11'd688;
  localparam logic [ID_W-1:0] ID_STATUS = 11'd656;

  localparam logic [7:0] CRC_POLY  = 8'h1D;
  localparam logic [3:0] ALIVE_MAX = 4'd14;

  localparam logic [CFG_DATA_W-1:0] RST_SPEED_PERIOD  = 16'd100;
  localparam logic [CFG_DATA_W-1:0] RST_STATUS_PERIOD = 16'd10;
  localparam logic [CFG_DATA_W-1:0] RST_DATA_ID       = 16'h0014;

  // Positions of the signals in the store.
  localparam logic [IDX_W-1:0] IDX_CRC           = 4'd0;
  localparam logic [IDX_W-1:0] IDX_ALIVE         = 4'd1;
  localparam logic [IDX_W-1:0] IDX_SPEED_REAR    = 4'd2;
  localparam logic [IDX_W-1:0] IDX_SPEED_FRONT   = 4'd3;
  localparam logic [IDX_W-1:0] IDX_BRAKE_FRONT   = 4'd4;
  localparam logic [IDX_W-1:0] IDX_BRAKE_REAR    = 4'd5;
  localparam logic [IDX_W-1:0] IDX_ABS           = 4'd6;
  localparam logic [IDX_W-1:0] IDX_SENSOR_FRONT  = 4'd7;
  localparam logic [IDX_W-1:0] IDX_SENSOR_REAR   = 4'd8;
  localparam logic [IDX_W-1:0] IDX_STAND         = 4'd9;
  localparam logic [IDX_W-1:0] IDX_MODE_CHANGE   = 4'd10;
  localparam logic [IDX_W-1:0] IDX_MODE_ACTIVE   = 4'd11;
  localparam logic [IDX_W-1:0] IDX_TILT_MODE     = 4'd12;
  localparam logic [IDX_W-1:0] IDX_TILT_LOCK     = 4'd13;
  localparam logic [IDX_W-1:0] IDX_MILEAGE_FRONT = 4'd14;
  localparam logic [IDX_W-1:0] IDX_MILEAGE_REAR  = 4'd15;

  typedef enum logic [OP_W-1:0] {
    OP_TICK = 2'd0,
    OP_SET  = 2'd1,
    OP_INIT = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALIVE_EN      = 3'd0,
    REG_CRC_EN        = 3'd1,
    REG_SPEED_PERIOD  = 3'd2,
    REG_STATUS_PERIOD = 3'd3,
    REG_DATA_ID       = 3'd4
  } cfg_reg_t;

  typedef logic [SIG_COUNT-1:0][SIG_W-1:0] sig_store_t;

  // Reset image of the signal store: all zero except the two brakes.
  function automatic sig_store_t sig_store_reset();
    sig_store_t s;
    s = '0;
    s[IDX_BRAKE_FRONT] = 12'd1;
    s[IDX_BRAKE_REAR]  = 12'd1;
    return s;
  endfunction

  localparam sig_store_t SIG_STORE_RESET = sig_store_reset();

  typedef struct packed {
    logic                  alive_enable;
    logic                  crc_enable;
    logic [CFG_DATA_W-1:0] speed_period;
    logic [CFG_DATA_W-1:0] status_period;
    logic [CFG_DATA_W-1:0] data_id;
  } cfg_t;

  typedef struct packed {
    logic [ID_W-1:0]      can_id;
    logic [PAYLOAD_W-1:0] payload;
    logic                 last;
  } frame_t;

  // Mask of the bits that each signal occupies in the frames.
  function automatic logic [SIG_W-1:0] slot_mask(input logic [IDX_W-1:0] idx);
    logic [SIG_W-1:0] mask;
    case (idx)
      IDX_CRC:           mask = 12'h0FF;
      IDX_ALIVE:         mask = 12'h00F;
      IDX_SPEED_REAR:    mask = 12'hFFF;
      IDX_SPEED_FRONT:   mask = 12'hFFF;
      IDX_BRAKE_FRONT:   mask = 12'h003;
      IDX_BRAKE_REAR:    mask = 12'h003;
      IDX_ABS:           mask = 12'h00F;
      IDX_SENSOR_FRONT:  mask = 12'h003;
      IDX_SENSOR_REAR:   mask = 12'h003;
      IDX_STAND:         mask = 12'h007;
      IDX_MODE_CHANGE:   mask = 12'h003;
      IDX_MODE_ACTIVE:   mask = 12'h007;
      IDX_TILT_MODE:     mask = 12'h03F;
      IDX_TILT_LOCK:     mask = 12'h003;
      IDX_MILEAGE_FRONT: mask = 12'hFFF;
      IDX_MILEAGE_REAR:  mask = 12'hFFF;
      default:           mask = 12'h000;
    endcase
    return mask;
  endfunction

  // The CRC has init zero and no final xor, so it is linear in the message.
  // Column p is the CRC of a message holding only bit p; the message is fed
  // most significant bit first.
  function automatic logic [CRC_MSG_W-1:0][7:0] crc8_cols();
    logic [CRC_MSG_W-1:0][7:0] cols;
    logic [7:0]                crc;
    logic                      fb;
    for (int p = 0; p < CRC_MSG_W; p++) begin
      crc = 8'h00;
      for (int j = CRC_MSG_W - 1; j >= 0; j--) begin
        fb  = crc[7] ^ (j == p);
        crc = {crc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
      end
      cols[p] = crc;
    end
    return cols;
  endfunction

  localparam logic [CRC_MSG_W-1:0][7:0] CRC_COLS = crc8_cols();

  function automatic logic [7:0] crc8_msg(input logic [CRC_MSG_W-1:0] msg);
    logic [7:0] crc;
    crc = 8'h00;
    for (int p = 0; p < CRC_MSG_W; p++) begin
      crc = crc ^ (msg[p] ? CRC_COLS[p] : 8'h00);
    end
    return crc;
  endfunction

endpackage

/* sv/can_frame_crc8_alive_generator_top.sv */
// A request is held in the input register, then its frames enter the output queue.
// Throughput: one request per cycle while the output queue has room; a tick that sends
// both frames needs both entries of the two-entry output queue free before it is taken.
// Reset (rst_n low, synchronous): signals zero except both brakes at one, timer starts
// zero, registers at their defaults, input register and output queue empty.
module can_frame_crc8_alive_generator_top #(
  parameter int TIME_WIDTH = cfcag_pkg::TIME_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Request channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [cfcag_pkg::OP_W-1:0]        in_operation,
  input  logic [cfcag_pkg::IDX_W-1:0]       in_signal_index,
  input  logic [cfcag_pkg::SIG_W-1:0]       in_signal_value,
  input  logic [TIME_WIDTH-1:0]             in_current_time,
  // Frame channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [cfcag_pkg::ID_W-1:0]        out_can_id,
  output logic [cfcag_pkg::PAYLOAD_W-1:0]   out_payload,
  output logic                              out_last_of_run,
  // Register write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cfcag_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cfcag_pkg::CFG_DATA_W-1:0]  cfg_data
);

  `include "can_frame_crc8_alive_generator_top_assert.svh"

  // Elapsed time and period are compared at a width that holds both.
  localparam int CMP_W = (TIME_WIDTH > cfcag_pkg::CFG_DATA_W) ? TIME_WIDTH
                                                              : cfcag_pkg::CFG_DATA_W;

  // ------------------------------------------------------------------
  // Input register. It holds one request until the frame stage can take
  // it, which is whenever the output queue has room for all the frames
  // that the request produces.
  // ------------------------------------------------------------------
  logic                             in_vld_r;
  logic [cfcag_pkg::OP_W-1:0]       in_op_r;
  logic [cfcag_pkg::IDX_W-1:0]      in_idx_r;
  logic [cfcag_pkg::SIG_W-1:0]      in_val_r;
  logic [TIME_WIDTH-1:0]            in_time_r;
  logic                             in_vld_nxt;
  logic                             in_take;

  // Architectural state.
  cfcag_pkg::cfg_t                  cfg_r;
  cfcag_pkg::sig_store_t            sig_r;
  logic [TIME_WIDTH-1:0]            speed_start_r;
  logic [TIME_WIDTH-1:0]            status_start_r;

  // Output queue: entry 0 is what the frame channel shows.
  cfcag_pkg::frame_t                q0_r, q1_r;
  cfcag_pkg::frame_t                q0_nxt, q1_nxt;
  cfcag_pkg::frame_t                kept0, kept1;
  cfcag_pkg::frame_t                f0, f1;
  logic [1:0]                       cnt_r, cnt_nxt;
  logic [1:0]                       kept;
  logic [1:0]                       free;
  logic [1:0]                       nframes;
  logic                             pop;
  logic                             consume;

  logic                             tick;
  logic                             sp_due, st_due;
  logic [TIME_WIDTH-1:0]            sp_elapsed, st_elapsed;

  logic [cfcag_pkg::PAYLOAD_W-1:0]  speed_payload;
  logic [cfcag_pkg::PAYLOAD_W-1:0]  status_payload;
  logic [cfcag_pkg::SIG_W-1:0]      alive_nxt;
  logic [7:0]                       crc_nxt;

  // ------------------------------------------------------------------
  // Timers. The difference wraps modulo 2^TIME_WIDTH, so a timer keeps
  // working across a wrap of the time base; a zero period fires always.
  // ------------------------------------------------------------------
  assign tick       = in_vld_r && (cfcag_pkg::op_t'(in_op_r) == cfcag_pkg::OP_TICK);
  assign sp_elapsed = in_time_r - speed_start_r;
  assign st_elapsed = in_time_r - status_start_r;
  assign sp_due     = CMP_W'(sp_elapsed) >= CMP_W'(cfg_r.speed_period);
  assign st_due     = CMP_W'(st_elapsed) >= CMP_W'(cfg_r.status_period);
  assign nframes    = tick ? ({1'b0, sp_due} + {1'b0, st_due}) : 2'd0;

  // Frame contents, including the alive step and the CRC of the status frame.
  cfcag_frame_build u_frame_build (
    .cfg            (cfg_r),
    .sig            (sig_r),
    .speed_payload  (speed_payload),
    .status_payload (status_payload),
    .alive_nxt      (alive_nxt),
    .crc_nxt        (crc_nxt)
  );

  // The speed frame always goes first. The second slot only matters when
  // both timers fire, and then it carries the status frame.
  always_comb begin
    f0.can_id  = sp_due ? cfcag_pkg::ID_SPEED : cfcag_pkg::ID_STATUS;
    f0.payload = sp_due ? speed_payload : status_payload;
    f0.last    = !(sp_due && st_due);
    f1.can_id  = cfcag_pkg::ID_STATUS;
    f1.payload = status_payload;
    f1.last    = 1'b1;
  end

  // ------------------------------------------------------------------
  // Queue bookkeeping. A frame leaving this cycle frees its slot at once, so a
  // run of single-frame ticks flows at one request per cycle while out_stall is low.
  // ------------------------------------------------------------------
  assign out_valid       = (cnt_r != 2'd0);
  assign out_can_id      = q0_r.can_id;
  assign out_payload     = q0_r.payload;
  assign out_last_of_run = q0_r.last;

  assign pop     = out_valid && !out_stall;
  assign kept    = cnt_r - {1'b0, pop};
  assign free    = 2'd2 - kept;
  assign consume = in_vld_r && (nframes <= free);

  assign in_stall   = in_vld_r && !consume;
  assign in_take    = in_valid && !in_stall;
  assign in_vld_nxt = in_take || (in_vld_r && !consume);

  always_comb begin
    kept0   = pop ? q1_r : q0_r;
    kept1   = q1_r;
    cnt_nxt = kept + (consume ? nframes : 2'd0);
    q0_nxt  = (kept != 2'd0) ? kept0 : f0;
    if (kept == 2'd2) begin
      q1_nxt = kept1;
    end else if (kept == 2'd1) begin
      q1_nxt = f0;
    end else begin
      q1_nxt = f1;
    end
  end

  // Registers are written at any time; the user keeps the block idle then, unchecked.
  assign cfg_ready = 1'b1;

  // ------------------------------------------------------------------
  // Control and state registers.
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r            <= 1'b0;
      cnt_r               <= 2'd0;
      speed_start_r       <= '0;
      status_start_r      <= '0;
      sig_r               <= cfcag_pkg::SIG_STORE_RESET;
      cfg_r.alive_enable  <= 1'b0;
      cfg_r.crc_enable    <= 1'b0;
      cfg_r.speed_period  <= cfcag_pkg::RST_SPEED_PERIOD;
      cfg_r.status_period <= cfcag_pkg::RST_STATUS_PERIOD;
      cfg_r.data_id       <= cfcag_pkg::RST_DATA_ID;
    end else begin
      in_vld_r <= in_vld_nxt;
      cnt_r    <= cnt_nxt;

      if (cfg_valid && cfg_ready) begin
        case (cfcag_pkg::cfg_reg_t'(cfg_index))
          cfcag_pkg::REG_ALIVE_EN:      cfg_r.alive_enable  <= cfg_data[0];
          cfcag_pkg::REG_CRC_EN:        cfg_r.crc_enable    <= cfg_data[0];
          cfcag_pkg::REG_SPEED_PERIOD:  cfg_r.speed_period  <= cfg_data;
          cfcag_pkg::REG_STATUS_PERIOD: cfg_r.status_period <= cfg_data;
          cfcag_pkg::REG_DATA_ID:       cfg_r.data_id       <= cfg_data;
          default: ;
        endcase
      end

      if (consume) begin
        case (cfcag_pkg::op_t'(in_op_r))
          cfcag_pkg::OP_SET: begin
            sig_r[in_idx_r] <= in_val_r & cfcag_pkg::slot_mask(in_idx_r);
          end
          cfcag_pkg::OP_INIT: begin
            speed_start_r  <= in_time_r;
            status_start_r <= in_time_r;
          end
          cfcag_pkg::OP_TICK: begin
            if (sp_due) begin
              speed_start_r <= in_time_r;
            end
            if (st_due) begin
              // The status frame writes its alive count and CRC back.
              status_start_r           <= in_time_r;
              sig_r[cfcag_pkg::IDX_ALIVE] <= alive_nxt;
              sig_r[cfcag_pkg::IDX_CRC]   <= {4'h0, crc_nxt};
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_op_r   <= in_operation;
      in_idx_r  <= in_signal_index;
      in_val_r  <= in_signal_value;
      in_time_r <= in_current_time;
    end
    q0_r <= q0_nxt;
    q1_r <= q1_nxt;
  end

  // ------------------------------------------------------------------
  // Assertions.
  // ------------------------------------------------------------------
  `CFCAG_ASSERT_SAME(a_queue_bound, 1'b1, cnt_r != 2'd3)
  `CFCAG_ASSERT_SAME(a_pair_needs_room, consume && (nframes == 2'd2), free == 2'd2)
  `CFCAG_ASSERT_NEXT(a_alive_wraps, consume && tick && st_due && cfg_r.alive_enable,
                     sig_r[cfcag_pkg::IDX_ALIVE] <= 12'd14)
  `CFCAG_ASSERT_NEXT(a_speed_restart, consume && tick && sp_due,
                     speed_start_r == $past(in_time_r))

endmodule

/* sv/cfcag_frame_build.sv */
module cfcag_frame_build (
  input  cfcag_pkg::cfg_t                     cfg,
  input  cfcag_pkg::sig_store_t               sig,
  output logic [cfcag_pkg::PAYLOAD_W-1:0]     speed_payload,
  output logic [cfcag_pkg::PAYLOAD_W-1:0]     status_payload,
  output logic [cfcag_pkg::SIG_W-1:0]         alive_nxt,
  output logic [7:0]                          crc_nxt
);

  logic [cfcag_pkg::SIG_W-1:0] rr;
  logic [cfcag_pkg::SIG_W-1:0] ft;
  logic [cfcag_pkg::SIG_W-1:0] alive;
  logic [7:0]                  d1, d2, d3, d4, d5, d6, d7;
  logic [7:0]                  crc_calc;

  assign rr = sig[cfcag_pkg::IDX_MILEAGE_REAR];
  assign ft = sig[cfcag_pkg::IDX_MILEAGE_FRONT];

  assign speed_payload = {8'hFF, 8'hFF, 8'hFF, {4'hF, ft[11:8]}, ft[7:0], rr[11:4],
                          {rr[3:0], 4'hF}, 8'hFF};

  // When enabled, the alive counter wraps to zero from fourteen or anything above it.
  assign alive = sig[cfcag_pkg::IDX_ALIVE];
  always_comb begin
    if (!cfg.alive_enable) begin
      alive_nxt = alive;
    end else if (alive >= cfcag_pkg::SIG_W'(cfcag_pkg::ALIVE_MAX)) begin
      alive_nxt = '0;
    end else begin
      alive_nxt = alive + 12'd1;
    end
  end

  assign d1 = {sig[cfcag_pkg::IDX_SPEED_REAR][3:0], alive_nxt[3:0]};
  assign d2 = sig[cfcag_pkg::IDX_SPEED_REAR][11:4];
  assign d3 = sig[cfcag_pkg::IDX_SPEED_FRONT][7:0];
  assign d4 = {sig[cfcag_pkg::IDX_BRAKE_FRONT][1:0], sig[cfcag_pkg::IDX_BRAKE_REAR][1:0],
               sig[cfcag_pkg::IDX_SPEED_FRONT][11:8]};
  assign d5 = {sig[cfcag_pkg::IDX_ABS][3:0], sig[cfcag_pkg::IDX_SENSOR_FRONT][1:0],
               sig[cfcag_pkg::IDX_SENSOR_REAR][1:0]};
  assign d6 = {sig[cfcag_pkg::IDX_STAND][2:0], sig[cfcag_pkg::IDX_MODE_CHANGE][1:0],
               sig[cfcag_pkg::IDX_MODE_ACTIVE][2:0]};
  assign d7 = {sig[cfcag_pkg::IDX_TILT_MODE][5:0], sig[cfcag_pkg::IDX_TILT_LOCK][1:0]};

  assign crc_calc = cfcag_pkg::crc8_msg({cfg.data_id[7:0], cfg.data_id[15:8],
                                         d1, d2, d3, d4, d5, d6, d7});
  assign crc_nxt  = cfg.crc_enable ? crc_calc : sig[cfcag_pkg::IDX_CRC][7:0];

  assign status_payload = {d7, d6, d5, d4, d3, d2, d1, crc_nxt};

endmodule

/* tb/can_frame_crc8_alive_generator_top_test.sv */
`timescale 1ns / 100ps

module can_frame_crc8_alive_generator_top_test;
  import cfcag_pkg::*;

  localparam int TW = TIME_WIDTH_DEF;

  // Operation code 3 has no meaning; the block must ignore such a request.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // Register indexes above the data identifier select nothing.
  localparam logic [CFG_IDX_W-1:0] FIRST_SPARE_REG = 3'd5;
  localparam logic [CFG_IDX_W-1:0] LAST_SPARE_REG  = 3'd7;

  // Width of each signal's slot in the frames, entry 15 first.
  localparam logic [SIG_COUNT-1:0][3:0] SLOT_WIDTHS = {
    4'd12, 4'd12, 4'd2, 4'd6, 4'd3, 4'd2, 4'd3, 4'd2,
    4'd2, 4'd4, 4'd2, 4'd2, 4'd12, 4'd12, 4'd4, 4'd8
  };

  localparam logic [7:0] FILL_BYTE   = 8'hFF;
  localparam logic [3:0] FILL_NIBBLE = 4'hF;

  localparam int SETTLE_CYCLES   = 8;
  localparam int LONG_HOLD       = 300;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int RANDOM_REQUESTS = 900;
  localparam int RANDOM_BLOCKS   = 8;
  localparam int JUNK_W          = CFG_DATA_W - 1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [OP_W-1:0]       in_operation = OP_TICK;
  logic [IDX_W-1:0]      in_signal_index = '0;
  logic [SIG_W-1:0]      in_signal_value = '0;
  logic [TW-1:0]         in_current_time = '0;

  logic                  out_valid;
  logic                  out_stall = 1'b1;
  logic [ID_W-1:0]       out_can_id;
  logic [PAYLOAD_W-1:0]  out_payload;
  logic                  out_last_of_run;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_ALIVE_EN;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  can_frame_crc8_alive_generator_top u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_signal_index (in_signal_index),
    .in_signal_value (in_signal_value),
    .in_current_time (in_current_time),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_can_id      (out_can_id),
    .out_payload     (out_payload),
    .out_last_of_run (out_last_of_run),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // The testbench's own picture of the generator: signal store, timer starts
  // and register settings, updated as each request or register write is taken.
  logic [SIG_W-1:0]      model_signals [SIG_COUNT];
  logic [TW-1:0]         model_speed_start;
  logic [TW-1:0]         model_status_start;
  logic                  model_alive_en;
  logic                  model_crc_en;
  logic [CFG_DATA_W-1:0] model_speed_period;
  logic [CFG_DATA_W-1:0] model_status_period;
  logic [CFG_DATA_W-1:0] model_data_id;

  // Frames that the block owes us, oldest first.
  frame_t pending_frames [$];

  int failures = 0;
  int cycle_count = 0;
  int request_idle_pct = 0;
  int frame_stall_pct = 0;
  int long_hold_requests = 0;
  int long_holds_taken = 0;
  int hold_left = 0;

  // Running time stamp for the stimulus; it mostly moves forward but now and
  // then jumps or steps back so that the wrapped elapsed time is exercised.
  logic [TW-1:0] stim_time = '0;

  always #1 clk = ~clk;

  // A hard ceiling on the run, far above the slowest correct run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic note_failure(input string msg);
    $display("mismatch: %s", msg);
    failures++;
  endtask

  task automatic reset_model();
    for (int i = 0; i < SIG_COUNT; i++) begin
      model_signals[i] = '0;
    end
    model_signals[IDX_BRAKE_FRONT] = 12'd1;
    model_signals[IDX_BRAKE_REAR]  = 12'd1;
    model_speed_start   = '0;
    model_status_start  = '0;
    model_alive_en      = 1'b0;
    model_crc_en        = 1'b0;
    model_speed_period  = RST_SPEED_PERIOD;
    model_status_period = RST_STATUS_PERIOD;
    model_data_id       = RST_DATA_ID;
  endtask

  task automatic update_model_register(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_ALIVE_EN:      model_alive_en = data[0];
      REG_CRC_EN:        model_crc_en = data[0];
      REG_SPEED_PERIOD:  model_speed_period = data;
      REG_STATUS_PERIOD: model_status_period = data;
      REG_DATA_ID:       model_data_id = data;
      default: begin
      end
    endcase
  endtask

  // One byte through the CRC-8 shift register, most significant bit first.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  // Status frame image built from the current store.
  function automatic logic [PAYLOAD_W-1:0] status_payload();
    logic [7:0] b [8];
    b[0] = model_signals[IDX_CRC][7:0];
    b[1] = {model_signals[IDX_SPEED_REAR][3:0], model_signals[IDX_ALIVE][3:0]};
    b[2] = model_signals[IDX_SPEED_REAR][11:4];
    b[3] = model_signals[IDX_SPEED_FRONT][7:0];
    b[4] = {model_signals[IDX_BRAKE_FRONT][1:0], model_signals[IDX_BRAKE_REAR][1:0],
            model_signals[IDX_SPEED_FRONT][11:8]};
    b[5] = {model_signals[IDX_ABS][3:0], model_signals[IDX_SENSOR_FRONT][1:0],
            model_signals[IDX_SENSOR_REAR][1:0]};
    b[6] = {model_signals[IDX_STAND][2:0], model_signals[IDX_MODE_CHANGE][1:0],
            model_signals[IDX_MODE_ACTIVE][2:0]};
    b[7] = {model_signals[IDX_TILT_MODE][5:0], model_signals[IDX_TILT_LOCK][1:0]};
    return {b[7], b[6], b[5], b[4], b[3], b[2], b[1], b[0]};
  endfunction

  // Works out the frames that one accepted request causes and queues them.
  task automatic predict_frames(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                                input logic [SIG_W-1:0] val, input logic [TW-1:0] now);
    frame_t               speed_frame;
    frame_t               status_frame;
    logic [TW-1:0]        speed_elapsed;
    logic [TW-1:0]        status_elapsed;
    logic                 speed_due;
    logic                 status_due;
    logic [SIG_W-1:0]     rear;
    logic [SIG_W-1:0]     front;
    logic [7:0]           crc;
    logic [PAYLOAD_W-1:0] image;
    case (op)
      OP_SET: begin
        model_signals[idx] = val & (12'hFFF >> (SIG_W - SLOT_WIDTHS[idx]));
      end
      OP_INIT: begin
        model_speed_start  = now;
        model_status_start = now;
      end
      OP_TICK: begin
        // Both timers compare the wrapped elapsed time against their period.
        speed_elapsed  = now - model_speed_start;
        status_elapsed = now - model_status_start;
        speed_due  = speed_elapsed >= TW'(model_speed_period);
        status_due = status_elapsed >= TW'(model_status_period);
        if (speed_due) begin
          model_speed_start = now;
          rear  = model_signals[IDX_MILEAGE_REAR];
          front = model_signals[IDX_MILEAGE_FRONT];
          speed_frame.can_id  = ID_SPEED;
          speed_frame.payload = {FILL_BYTE, FILL_BYTE, FILL_BYTE, {FILL_NIBBLE, front[11:8]},
                                 front[7:0], rear[11:4], {rear[3:0], FILL_NIBBLE}, FILL_BYTE};
          speed_frame.last    = !status_due;
          pending_frames.push_back(speed_frame);
        end
        if (status_due) begin
          model_status_start = now;
          // The alive counter steps first, so the CRC covers the new value.
          if (model_alive_en) begin
            if (model_signals[IDX_ALIVE] >= SIG_W'(ALIVE_MAX)) begin
              model_signals[IDX_ALIVE] = '0;
            end else begin
              model_signals[IDX_ALIVE] = model_signals[IDX_ALIVE] + 1'b1;
            end
          end
          if (model_crc_en) begin
            image = status_payload();
            crc = crc8_update(8'h00, model_data_id[7:0]);
            crc = crc8_update(crc, model_data_id[15:8]);
            for (int k = 1; k < 8; k++) begin
              crc = crc8_update(crc, image[8*k +: 8]);
            end
            model_signals[IDX_CRC] = {4'h0, crc};
          end
          status_frame.can_id  = ID_STATUS;
          status_frame.payload = status_payload();
          status_frame.last    = 1'b1;
          pending_frames.push_back(status_frame);
        end
      end
      default: begin
      end
    endcase
  endtask

  // Every accepted frame is held against the oldest one still owed.
  always @(posedge clk) begin : check_frames
    frame_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_frames.size() == 0) begin
        note_failure($sformatf("unexpected frame id %0d payload %h", out_can_id, out_payload));
      end else begin
        want = pending_frames.pop_front();
        if (out_can_id !== want.can_id) begin
          note_failure($sformatf("can_id %0d, wanted %0d", out_can_id, want.can_id));
        end
        if (out_payload !== want.payload) begin
          note_failure($sformatf("payload %h, wanted %h (id %0d)", out_payload, want.payload,
                                 want.can_id));
        end
        if (out_last_of_run !== want.last) begin
          note_failure($sformatf("last_of_run %b, wanted %b (id %0d)", out_last_of_run,
                                 want.last, want.can_id));
        end
      end
    end
  end

  // Frame receiver. It normally stalls at the rate of the current phase, but
  // when asked it holds off for a long stretch so that the block's output
  // queue fills and the request side backs up.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (long_holds_taken != long_hold_requests) begin
      long_holds_taken = long_hold_requests;
      hold_left = LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < frame_stall_pct);
    end
  end

  // Offers one request, idling beforehand at the phase's rate, and waits for
  // the block to take it. Valid stays high on return so that back-to-back
  // requests need no gap.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                              input logic [SIG_W-1:0] val, input logic [TW-1:0] now);
    while ($urandom_range(99) < request_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_operation    <= op;
    in_signal_index <= idx;
    in_signal_value <= val;
    in_current_time <= now;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    predict_frames(op, idx, val, now);
  endtask

  // Lets the block run dry: no request offered, every owed frame delivered,
  // then a further wait for anything still in flight.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_frames.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    update_model_register(idx, data);
  endtask

  // Writes every register, plus one spare index that must change nothing.
  // The enable bits travel with random upper bits, which the block drops.
  task automatic apply_settings(input logic alive_en, input logic crc_en,
                                input logic [CFG_DATA_W-1:0] speed_period,
                                input logic [CFG_DATA_W-1:0] status_period,
                                input logic [CFG_DATA_W-1:0] data_id);
    logic [CFG_DATA_W-2:0] junk;
    logic [CFG_IDX_W-1:0]  spare;
    junk = JUNK_W'($urandom);
    write_register(REG_ALIVE_EN, {junk, alive_en});
    junk = JUNK_W'($urandom);
    write_register(REG_CRC_EN, {junk, crc_en});
    write_register(REG_SPEED_PERIOD, speed_period);
    write_register(REG_STATUS_PERIOD, status_period);
    write_register(REG_DATA_ID, data_id);
    spare = CFG_IDX_W'($urandom_range(LAST_SPARE_REG, FIRST_SPARE_REG));
    write_register(spare, CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Reset values of the timers: nothing before the status period, the status
  // frame alone at its period, both frames at the speed period, and a status
  // frame after an init just below the wrap point of the time counter. An
  // unused operation code in between must cause nothing.
  task automatic test_default_timers();
    send_request(OP_TICK, IDX_W'($urandom), SIG_W'($urandom), 32'd5);
    send_request(OP_TICK, IDX_W'($urandom), SIG_W'($urandom), 32'd10);
    send_request(OP_TICK, IDX_W'($urandom), SIG_W'($urandom), 32'd100);
    send_request(OP_UNUSED, IDX_W'($urandom), SIG_W'($urandom), $urandom);
    send_request(OP_INIT, IDX_W'($urandom), SIG_W'($urandom), 32'hFFFF_FFF0);
    stim_time = 32'h0000_0010;
    send_request(OP_TICK, IDX_W'($urandom), SIG_W'($urandom), stim_time);
    settle();
  endtask

  // Zero periods make every tick send both frames. Each signal is written
  // with an all-ones value so that the masking of every slot shows up.
  task automatic test_signal_masking();
    apply_settings(1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000);
    for (int i = 0; i < SIG_COUNT; i++) begin
      send_request(OP_SET, IDX_W'(i), 12'hFFF, $urandom);
    end
    send_request(OP_TICK, IDX_W'($urandom), SIG_W'($urandom), stim_time);
    settle();
  endtask

  // Alive counter stepping up to its top value and wrapping, with the CRC
  // over an all-ones data identifier; then the speed timer at its longest
  // period, reached exactly.
  task automatic test_alive_and_crc();
    apply_settings(1'b1, 1'b1, 16'hFFFF, 16'h0000, 16'hFFFF);
    send_request(OP_SET, IDX_ALIVE, 12'd13, $urandom);
    stim_time = stim_time + 1;
    send_request(OP_TICK, IDX_W'($urandom), SIG_W'($urandom), stim_time);
    stim_time = stim_time + 1;
    send_request(OP_TICK, IDX_W'($urandom), SIG_W'($urandom), stim_time);
    stim_time = model_speed_start + 32'd65535;
    send_request(OP_TICK, IDX_W'($urandom), SIG_W'($urandom), stim_time);
    settle();
  endtask

  // The receiver stops for a long stretch while ticks keep coming, each one
  // owing two frames, so the block must hold its request side off.
  task automatic test_output_backpressure();
    apply_settings(1'b1, 1'b1, 16'h0000, 16'h0000, CFG_DATA_W'($urandom));
    request_idle_pct = 0;
    frame_stall_pct  = 0;
    long_hold_requests++;
    for (int i = 0; i < 40; i++) begin
      stim_time = stim_time + 1;
      send_request(OP_TICK, IDX_W'($urandom), SIG_W'($urandom), stim_time);
    end
    settle();
  endtask

  // One random request. Ticks are the bulk; their time mostly advances by
  // about a status period, with the odd jump anywhere or step backwards.
  // Requests with the unused code are not counted.
  task automatic random_request(output bit counted);
    int pick;
    pick = $urandom_range(99);
    counted = 1'b1;
    if (pick < 55) begin
      case ($urandom_range(15))
        0: stim_time = $urandom;
        1: stim_time = stim_time - $urandom_range(40, 1);
        2: stim_time = stim_time + $urandom_range(65535);
        default: stim_time = stim_time + $urandom_range(2 * model_status_period + 2);
      endcase
      send_request(OP_TICK, IDX_W'($urandom), SIG_W'($urandom), stim_time);
    end else if (pick < 85) begin
      send_request(OP_SET, IDX_W'($urandom), SIG_W'($urandom), $urandom);
    end else if (pick < 93) begin
      if ($urandom_range(1)) begin
        stim_time = $urandom;
      end
      send_request(OP_INIT, IDX_W'($urandom), SIG_W'($urandom), stim_time);
    end else begin
      send_request(OP_UNUSED, IDX_W'($urandom), SIG_W'($urandom), $urandom);
      counted = 1'b0;
    end
  endtask

  // Blocks of random traffic, each under its own register settings and its
  // own idling pattern: none, sender idle, receiver stalling, then both.
  // The first two blocks use the extreme periods and data identifiers.
  task automatic test_random_traffic();
    int  sent;
    bit  counted;
    for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      if (blk == 0) begin
        apply_settings(1'b0, 1'b1, 16'd1, 16'hFFFF, 16'hFFFF);
      end else if (blk == 1) begin
        apply_settings(1'b1, 1'b0, 16'hFFFF, 16'd1, 16'h0000);
      end else begin
        apply_settings(1'($urandom), 1'($urandom), CFG_DATA_W'($urandom_range(60, 1)),
                       CFG_DATA_W'($urandom_range(20, 1)), CFG_DATA_W'($urandom));
      end
      case (blk % 4)
        0: begin request_idle_pct = 0;  frame_stall_pct = 0;  end
        1: begin request_idle_pct = 56; frame_stall_pct = 0;  end
        2: begin request_idle_pct = 0;  frame_stall_pct = 56; end
        default: begin request_idle_pct = 15; frame_stall_pct = 15; end
      endcase
      sent = 0;
      while (sent < RANDOM_REQUESTS / RANDOM_BLOCKS) begin
        random_request(counted);
        if (counted) begin
          sent++;
        end
      end
      settle();
    end
  endtask

  initial begin
    reset_model();
    rst_n <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_default_timers();
    test_signal_masking();
    test_alive_and_crc();
    test_output_backpressure();
    test_random_traffic();
    if (pending_frames.size() != 0) begin
      note_failure($sformatf("%0d frames never arrived", pending_frames.size()));
    end
    if (failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
